@@ design/hkrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types and constants for the boot-keyboard report differ.
// ----------------------------------------------------------------------------
package hkrd_pkg;

    localparam int MOD_W       = 8;
    localparam int LED_W       = 3;
    localparam int CODE_W      = 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [CODE_W-1:0] USAGE_NUM_LOCK    = 8'd83;
    localparam logic [CODE_W-1:0] USAGE_CAPS_LOCK   = 8'd57;
    localparam logic [CODE_W-1:0] USAGE_SCROLL_LOCK = 8'd71;
    localparam logic [CODE_W-1:0] USAGE_MOD_BASE    = 8'd224;

    // event slot layout: num lock x3, caps lock x3, scroll lock, modifiers, key slots x2
    localparam int EV_NUM        = 0;
    localparam int EV_CAPS       = 3;
    localparam int EV_SCROLL     = 6;
    localparam int EV_MOD_FIRST  = 7;
    localparam int EV_SLOT_FIRST = EV_MOD_FIRST + MOD_W;

    localparam int LED_NUM    = 0;
    localparam int LED_CAPS   = 1;
    localparam int LED_SCROLL = 2;

    typedef struct packed {
        logic capture;
        logic load;
        logic emit;
        logic commit;
    } hkrd_cmd_t;

    typedef struct packed {
        logic cand_any;
        logic last;
        logic out_free;
    } hkrd_sts_t;

endpackage
`default_nettype wire

@@ design/hkrd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_ctrl
// Sequencer: captures a report, builds the event mask, emits one event per
// free output slot and commits the new state with the final event, or right
// after the load if the report yields no event.
module hkrd_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  hkrd_pkg::hkrd_sts_t sts,
    output hkrd_pkg::hkrd_cmd_t cmd
);
    import hkrd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
                if (sts.cand_any) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ design/hkrd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_datapath
// Report capture, kept state, pending event mask and output register.
// ----------------------------------------------------------------------------
module hkrd_datapath #(
    parameter int KEY_SLOTS = 6,
    parameter int S_TDATA_W = 64
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire  [S_TDATA_W-1:0]           s_tdata,
    input  hkrd_pkg::hkrd_cmd_t            cmd,
    output hkrd_pkg::hkrd_sts_t            sts,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [hkrd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import hkrd_pkg::*;

    localparam int NUM_EV = EV_SLOT_FIRST + 2 * KEY_SLOTS;
    localparam int IDX_W  = $clog2(NUM_EV);

    logic [MOD_W-1:0]  rep_mods_reg;
    logic [LED_W-1:0]  rep_leds_reg;
    logic [CODE_W-1:0] rep_slots_reg [KEY_SLOTS];

    logic [MOD_W-1:0]  prev_mods_reg;
    logic [LED_W-1:0]  lock_flags_reg;
    logic [CODE_W-1:0] prev_slots_reg [KEY_SLOTS];

    logic [NUM_EV-1:0] mask_reg, mask_next;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_press_reg;
    logic              out_last_reg;

    logic [NUM_EV-1:0] cand_valid;
    logic [CODE_W-1:0] cand_code  [NUM_EV];
    logic              cand_press [NUM_EV];
    logic [IDX_W-1:0]  ev_idx;
    logic [NUM_EV-1:0] mask_rest;
    logic              lock_on;
    logic              lock_off;

    // candidate events of the held report against the kept state
    always_comb begin
        cand_valid = '0;
        for (int k = 0; k < NUM_EV; k++) begin
            cand_code[k]  = '0;
            cand_press[k] = 1'b0;
        end
        lock_on  = 1'b0;
        lock_off = 1'b0;

        lock_on  = rep_leds_reg[LED_NUM] & ~lock_flags_reg[LED_NUM];
        lock_off = ~rep_leds_reg[LED_NUM] & lock_flags_reg[LED_NUM];
        cand_valid[EV_NUM]     = lock_on | lock_off;
        cand_valid[EV_NUM + 1] = lock_off;
        cand_valid[EV_NUM + 2] = lock_off;
        cand_code[EV_NUM]      = USAGE_NUM_LOCK;
        cand_code[EV_NUM + 1]  = USAGE_NUM_LOCK;
        cand_code[EV_NUM + 2]  = USAGE_NUM_LOCK;
        cand_press[EV_NUM]     = rep_leds_reg[LED_NUM];
        cand_press[EV_NUM + 1] = 1'b1;
        cand_press[EV_NUM + 2] = 1'b0;

        lock_on  = rep_leds_reg[LED_CAPS] & ~lock_flags_reg[LED_CAPS];
        lock_off = ~rep_leds_reg[LED_CAPS] & lock_flags_reg[LED_CAPS];
        cand_valid[EV_CAPS]     = lock_on | lock_off;
        cand_valid[EV_CAPS + 1] = lock_off;
        cand_valid[EV_CAPS + 2] = lock_off;
        cand_code[EV_CAPS]      = USAGE_CAPS_LOCK;
        cand_code[EV_CAPS + 1]  = USAGE_CAPS_LOCK;
        cand_code[EV_CAPS + 2]  = USAGE_CAPS_LOCK;
        cand_press[EV_CAPS]     = rep_leds_reg[LED_CAPS];
        cand_press[EV_CAPS + 1] = 1'b1;
        cand_press[EV_CAPS + 2] = 1'b0;

        cand_valid[EV_SCROLL] = rep_leds_reg[LED_SCROLL] ^ lock_flags_reg[LED_SCROLL];
        cand_code[EV_SCROLL]  = USAGE_SCROLL_LOCK;
        cand_press[EV_SCROLL] = rep_leds_reg[LED_SCROLL];

        for (int b = 0; b < MOD_W; b++) begin
            cand_valid[EV_MOD_FIRST + b] = rep_mods_reg[b] ^ prev_mods_reg[b];
            cand_code[EV_MOD_FIRST + b]  = USAGE_MOD_BASE | CODE_W'(b);
            cand_press[EV_MOD_FIRST + b] = rep_mods_reg[b];
        end

        for (int j = 0; j < KEY_SLOTS; j++) begin
            cand_valid[EV_SLOT_FIRST + 2*j] = (rep_slots_reg[j] != prev_slots_reg[j])
                                            && (prev_slots_reg[j] != '0);
            cand_valid[EV_SLOT_FIRST + 2*j + 1] = (rep_slots_reg[j] != prev_slots_reg[j])
                                                && (rep_slots_reg[j] != '0);
            cand_code[EV_SLOT_FIRST + 2*j]      = prev_slots_reg[j];
            cand_code[EV_SLOT_FIRST + 2*j + 1]  = rep_slots_reg[j];
            cand_press[EV_SLOT_FIRST + 2*j]     = 1'b0;
            cand_press[EV_SLOT_FIRST + 2*j + 1] = 1'b1;
        end
    end

    // lowest pending event
    always_comb begin
        ev_idx = '0;
        for (int k = NUM_EV - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                ev_idx = IDX_W'(k);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - NUM_EV'(1));

    assign sts.cand_any = |cand_valid;
    assign sts.last     = (mask_rest == '0);
    assign sts.out_free = ~out_valid_reg | m_tready;

    always_comb begin
        mask_next = mask_reg;
        if (cmd.load) begin
            mask_next = cand_valid;
        end else if (cmd.emit) begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rep_mods_reg <= s_tdata[MOD_W-1:0];
            rep_leds_reg <= s_tdata[MOD_W +: LED_W];
            for (int j = 0; j < KEY_SLOTS; j++) begin
                rep_slots_reg[j] <= s_tdata[MOD_W + LED_W + CODE_W*j +: CODE_W];
            end
        end
        if (cmd.emit) begin
            out_code_reg  <= cand_code[ev_idx];
            out_press_reg <= cand_press[ev_idx];
            out_last_reg  <= (mask_rest == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mods_reg  <= '0;
            lock_flags_reg <= '0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                prev_slots_reg[j] <= '0;
            end
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (cmd.commit) begin
                prev_mods_reg  <= rep_mods_reg;
                lock_flags_reg <= rep_leds_reg;
                for (int j = 0; j < KEY_SLOTS; j++) begin
                    prev_slots_reg[j] <= rep_slots_reg[j];
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = out_press_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

@@ design/hid_keyboard_report_differ.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ
// Turns boot-keyboard reports into key press/release events.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_       in   tdata: modifier_bits[7:0], lock_leds[10:8], key_slot_n at 11+8n, zero pad
// m_       out  tdata: scancode[7:0]; tuser: pressed; tlast: last_event
//
// A report is captured, its event mask is built, then its events (up to
// 15 + 2*KEY_SLOTS) are emitted one by one through the single output register.
// Reset clears the kept modifiers, slot codes and lock flags to zero.
// m_tready low holds the event sequencer; s_tready is high only between reports.
// ----------------------------------------------------------------------------
module hid_keyboard_report_differ #(
    parameter int KEY_SLOTS = 6
) (
    input  wire                                                   aclk,
    input  wire                                                   aresetn,
    input  wire                                                   s_tvalid,
    output logic                                                  s_tready,
    // modifier_bits, lock_leds, key_slot_0.. from the lowest bit
    input  wire  [((hkrd_pkg::MOD_W + hkrd_pkg::LED_W + hkrd_pkg::CODE_W*KEY_SLOTS + 7)/8)*8-1:0]
                                                                  s_tdata,
    output logic                                                  m_tvalid,
    input  wire                                                   m_tready,
    // scancode
    output logic [hkrd_pkg::M_TDATA_W-1:0]                        m_tdata,
    // pressed
    output logic                                                  m_tuser,
    output logic                                                  m_tlast
);
    import hkrd_pkg::*;

    localparam int S_TDATA_W = ((MOD_W + LED_W + CODE_W*KEY_SLOTS + 7) / 8) * 8;

    hkrd_cmd_t cmd;
    hkrd_sts_t sts;

    hkrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hkrd_datapath #(
        .KEY_SLOTS (KEY_SLOTS),
        .S_TDATA_W (S_TDATA_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ design/hkrd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkrd_checker
// Port-level checks on the report differ, bound to the top level.
// ----------------------------------------------------------------------------
module hkrd_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [hkrd_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire                              m_tuser,
    input wire                              m_tlast
);

    // event held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled event changed");

    // one report at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("report taken while busy");

    // between reports only the final event may still wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("input open with events outstanding");

    // more events follow a non-final transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("report closed before final event");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind hid_keyboard_report_differ hkrd_checker u_hkrd_checker (.*);
`default_nettype wire
